@@ rtl/sray_pkg.sv @@
// Shared types, constants and a lookup function for the sweeping ray/box range finder.
// No dependencies; every other file in rtl/ imports this package.
package sray_pkg;

    // obstacle table size and derived widths
    localparam int MAX_BOXES = 8;
    localparam int BOX_AW    = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
    localparam int CNT_W     = $clog2(MAX_BOXES + 1);
    localparam int EDGE_W    = $clog2(4 * MAX_BOXES + 5);

    // cordic / divider iteration count
    localparam int ITER_N = 16;
    localparam int ITER_W = 4;

    // configuration port
    localparam int CFG_AW = 3;
    localparam int CFG_DW = 24;

    typedef enum logic [CFG_AW-1:0] {
        CFG_SWEEP_MIN   = 3'd0,
        CFG_SWEEP_MAX   = 3'd1,
        CFG_SWEEP_STEP  = 3'd2,
        CFG_HALF_W      = 3'd3,
        CFG_HALF_H      = 3'd4,
        CFG_RANGE_LIMIT = 3'd5,
        CFG_SCAN_BUDGET = 3'd6,
        CFG_FIRST_SCAN  = 3'd7
    } cfg_addr_t;

    // request kinds
    typedef enum logic [1:0] {
        REQ_SCAN    = 2'd0,
        REQ_LOAD    = 2'd1,
        REQ_RESTART = 2'd2,
        REQ_UNUSED  = 2'd3
    } req_type_t;

    // reset values
    localparam logic signed [14:0] RST_SWEEP_MIN  = -15'sd5760;
    localparam logic signed [14:0] RST_SWEEP_MAX  = 15'sd5760;
    localparam logic [13:0]        RST_SWEEP_STEP = 14'd64;
    localparam logic [14:0]        RST_HALF_W     = 15'd1280;
    localparam logic [14:0]        RST_HALF_H     = 15'd1280;
    localparam logic [15:0]        RST_RANGE      = 16'd1810;
    localparam logic [23:0]        RST_BUDGET     = 24'd1000;
    localparam logic [23:0]        RST_FIRST      = 24'd0;

    // angle constants, 1/64 degree
    localparam logic signed [16:0] ANG_180 = 17'sd11520;
    localparam logic signed [16:0] ANG_360 = 17'sd23040;
    localparam logic signed [16:0] ANG_90  = 17'sd5760;

    localparam logic signed [18:0] CORDIC_GAIN = 19'sd39797;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CORDIC,
        ST_SEL,
        ST_MUL,
        ST_CHK,
        ST_TEST,
        ST_DIV,
        ST_COMMIT,
        ST_FINISH
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic              load_box;
        logic              restart;
        logic              cordic_init;
        logic              cordic_step;
        logic              edge_sel;
        logic              edge_mul;
        logic              edge_chk;
        logic              div_step;
        logic              commit;
        logic              finish;
        logic [ITER_W-1:0] iter;
        logic [EDGE_W-1:0] edge_idx;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic [CNT_W-1:0] box_count;
        logic             need_div;
    } stat_t;

    // scan result
    typedef struct packed {
        logic        budget_spent;
        logic [15:0] norm_range;
        logic [14:0] beam_angle;
    } res_t;

    // arctangent table, 1/65536 degree
    function automatic logic [22:0] atan_lut(input logic [ITER_W-1:0] i);
        logic [22:0] v;
        unique case (i)
            4'd0:    v = 23'd2949120;
            4'd1:    v = 23'd1740967;
            4'd2:    v = 23'd919879;
            4'd3:    v = 23'd466945;
            4'd4:    v = 23'd234379;
            4'd5:    v = 23'd117304;
            4'd6:    v = 23'd58666;
            4'd7:    v = 23'd29335;
            4'd8:    v = 23'd14668;
            4'd9:    v = 23'd7336;
            4'd10:   v = 23'd3667;
            4'd11:   v = 23'd1833;
            4'd12:   v = 23'd917;
            4'd13:   v = 23'd458;
            4'd14:   v = 23'd229;
            default: v = 23'd115;
        endcase
        return v;
    endfunction

endpackage

@@ rtl/sray_ctrl.sv @@
// Controller for the range finder: sequences cordic, per-edge tests and the divider.
// Depends on sray_pkg.
module sray_ctrl (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     in_accept,
    input  logic [1:0]               req_type,
    input  logic                     out_free,
    input  sray_pkg::stat_t          stat,
    output logic                     in_ready,
    output sray_pkg::cmd_t           cmd
);
    import sray_pkg::*;

    state_t              state_reg, state_next;
    logic [ITER_W-1:0]   iter_reg, iter_next;
    logic [EDGE_W-1:0]   edge_reg, edge_next;
    logic [EDGE_W-1:0]   edge_last;

    // last edge index: four walls plus four per stored box
    assign edge_last = EDGE_W'({stat.box_count, 2'b00}) + EDGE_W'(3);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            iter_reg  <= '0;
            edge_reg  <= '0;
        end else begin
            state_reg <= state_next;
            iter_reg  <= iter_next;
            edge_reg  <= edge_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        iter_next    = iter_reg;
        edge_next    = edge_reg;
        cmd          = '0;
        cmd.iter     = iter_reg;
        cmd.edge_idx = edge_reg;
        in_ready     = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                if (in_accept) begin
                    unique case (req_type_t'(req_type))
                        REQ_SCAN: begin
                            cmd.cordic_init = 1'b1;
                            iter_next       = '0;
                            state_next      = ST_CORDIC;
                        end
                        REQ_LOAD:    cmd.load_box = 1'b1;
                        REQ_RESTART: cmd.restart  = 1'b1;
                        default: ;
                    endcase
                end
            end
            ST_CORDIC: begin
                cmd.cordic_step = 1'b1;
                if (iter_reg == ITER_W'(ITER_N - 1)) begin
                    iter_next  = '0;
                    edge_next  = '0;
                    state_next = ST_SEL;
                end else begin
                    iter_next = iter_reg + 1'b1;
                end
            end
            ST_SEL: begin
                cmd.edge_sel = 1'b1;
                state_next   = ST_MUL;
            end
            ST_MUL: begin
                cmd.edge_mul = 1'b1;
                state_next   = ST_CHK;
            end
            ST_CHK: begin
                cmd.edge_chk = 1'b1;
                state_next   = ST_TEST;
            end
            ST_TEST: begin
                if (stat.need_div) begin
                    iter_next  = '0;
                    state_next = ST_DIV;
                end else begin
                    // no division needed: commit and move on
                    cmd.commit = 1'b1;
                    if (edge_reg == edge_last) begin
                        state_next = ST_FINISH;
                    end else begin
                        edge_next  = edge_reg + 1'b1;
                        state_next = ST_SEL;
                    end
                end
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (iter_reg == ITER_W'(ITER_N - 1)) begin
                    iter_next  = '0;
                    state_next = ST_COMMIT;
                end else begin
                    iter_next = iter_reg + 1'b1;
                end
            end
            ST_COMMIT: begin
                cmd.commit = 1'b1;
                if (edge_reg == edge_last) begin
                    state_next = ST_FINISH;
                end else begin
                    edge_next  = edge_reg + 1'b1;
                    state_next = ST_SEL;
                end
            end
            ST_FINISH: begin
                // wait for room in the output register
                if (out_free) begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule

@@ rtl/sray_dp.sv @@
// Datapath for the range finder: config and sweep registers, box table, cordic,
// edge test multipliers and the restoring divider. Depends on sray_pkg.
module sray_dp (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_we,
    input  logic [sray_pkg::CFG_AW-1:0] cfg_addr,
    input  logic [sray_pkg::CFG_DW-1:0] cfg_wdata,
    input  logic [63:0]                 box_data,
    input  sray_pkg::cmd_t              cmd,
    output sray_pkg::stat_t             stat,
    output sray_pkg::res_t              res
);
    import sray_pkg::*;

    // configuration registers
    logic signed [14:0] min_reg, max_reg;
    logic [13:0]        step_reg;
    logic [14:0]        hw_reg, hh_reg;
    logic [15:0]        range_reg;
    logic [23:0]        budget_reg, first_reg;

    // sweep state
    logic signed [15:0] ang_reg, ang_next;
    logic               down_reg, down_next;
    logic [23:0]        idx_reg, idx_next;
    logic [CNT_W-1:0]   cnt_reg;

    // box table, no reset
    logic signed [15:0] bcx_mem [MAX_BOXES];
    logic signed [15:0] bcy_mem [MAX_BOXES];
    logic [15:0]        bw_mem  [MAX_BOXES];
    logic [15:0]        bh_mem  [MAX_BOXES];

    // cordic
    logic signed [18:0] x_reg, y_reg;
    logic signed [25:0] z_reg;
    logic               neg_reg;
    logic signed [16:0] a_wrap, a_fold;
    logic               fold_neg;
    logic signed [18:0] dx_sh, dy_sh, cs, sn;
    logic signed [25:0] atan_v;

    // edge test
    logic signed [17:0] p_reg, p_sel;
    logic signed [18:0] d_reg, o_reg, d_sel, o_sel;
    logic signed [16:0] c_reg, c_sel;
    logic [15:0]        e_reg, e_sel;
    logic signed [36:0] po_reg;
    logic signed [35:0] cd_reg;
    logic [33:0]        ead_reg, den_reg;
    logic [17:0]        ap_reg;
    logic               pre_ok_reg;
    logic [17:0]        ad;
    logic signed [37:0] diff;
    logic [37:0]        adiff;
    logic               hit, sat;
    logic [32:0]        num_hi;
    logic               hit_reg, need_div_reg;

    // divider and best
    logic [33:0]        rem_reg;
    logic [34:0]        rem2;
    logic [15:0]        q_reg, best_reg;

    logic [EDGE_W-1:0]  edge_off;
    logic [BOX_AW-1:0]  bsel;
    logic signed [16:0] bx2, by2;
    logic signed [17:0] hw2, hh2;
    logic signed [16:0] sum_up, sum_dn;

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_reg    <= RST_SWEEP_MIN;
            max_reg    <= RST_SWEEP_MAX;
            step_reg   <= RST_SWEEP_STEP;
            hw_reg     <= RST_HALF_W;
            hh_reg     <= RST_HALF_H;
            range_reg  <= RST_RANGE;
            budget_reg <= RST_BUDGET;
            first_reg  <= RST_FIRST;
        end else if (cfg_we) begin
            unique case (cfg_addr_t'(cfg_addr))
                CFG_SWEEP_MIN:   min_reg    <= cfg_wdata[14:0];
                CFG_SWEEP_MAX:   max_reg    <= cfg_wdata[14:0];
                CFG_SWEEP_STEP:  step_reg   <= cfg_wdata[13:0];
                CFG_HALF_W:      hw_reg     <= cfg_wdata[14:0];
                CFG_HALF_H:      hh_reg     <= cfg_wdata[14:0];
                CFG_RANGE_LIMIT: range_reg  <= cfg_wdata[15:0];
                CFG_SCAN_BUDGET: budget_reg <= cfg_wdata[23:0];
                default:         first_reg  <= cfg_wdata[23:0];
            endcase
        end
    end

    // sweep update: bounce between the limits, counter saturates
    always_comb begin
        sum_up    = 17'(ang_reg) + $signed({3'b0, step_reg});
        sum_dn    = 17'(ang_reg) - $signed({3'b0, step_reg});
        ang_next  = ang_reg;
        down_next = down_reg;
        if (!down_reg) begin
            if (sum_up > 17'(max_reg)) begin
                down_next = 1'b1;
                ang_next  = 16'(max_reg);
            end else begin
                ang_next = sum_up[15:0];
            end
        end else begin
            if (sum_dn < 17'(min_reg)) begin
                down_next = 1'b0;
                ang_next  = 16'(min_reg);
            end else begin
                ang_next = sum_dn[15:0];
            end
        end
        idx_next = (idx_reg == 24'hFFFFFF) ? idx_reg : idx_reg + 24'd1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ang_reg  <= 16'(RST_SWEEP_MIN);
            down_reg <= 1'b0;
            idx_reg  <= RST_FIRST;
            cnt_reg  <= '0;
        end else begin
            if (cmd.restart) begin
                ang_reg  <= 16'(min_reg);
                down_reg <= 1'b0;
                idx_reg  <= first_reg;
            end else if (cmd.finish) begin
                ang_reg  <= ang_next;
                down_reg <= down_next;
                idx_reg  <= idx_next;
            end
            if (cmd.load_box && cnt_reg < CNT_W'(MAX_BOXES))
                cnt_reg <= cnt_reg + 1'b1;
        end
    end

    // box table write, loads into a full table are dropped
    always_ff @(posedge aclk) begin
        if (cmd.load_box && cnt_reg < CNT_W'(MAX_BOXES)) begin
            bcx_mem[cnt_reg[BOX_AW-1:0]] <= box_data[15:0];
            bcy_mem[cnt_reg[BOX_AW-1:0]] <= box_data[31:16];
            bw_mem[cnt_reg[BOX_AW-1:0]]  <= box_data[47:32];
            bh_mem[cnt_reg[BOX_AW-1:0]]  <= box_data[63:48];
        end
    end

    // angle wrap to +-180 and fold to +-90
    always_comb begin
        a_wrap = 17'(ang_reg);
        if (a_wrap > ANG_180)
            a_wrap = a_wrap - ANG_360;
        else if (a_wrap < -ANG_180)
            a_wrap = a_wrap + ANG_360;
        a_fold   = a_wrap;
        fold_neg = 1'b0;
        if (a_wrap > ANG_90) begin
            a_fold   = a_wrap - ANG_180;
            fold_neg = 1'b1;
        end else if (a_wrap < -ANG_90) begin
            a_fold   = a_wrap + ANG_180;
            fold_neg = 1'b1;
        end
    end

    // one cordic rotation per cycle
    assign dx_sh  = y_reg >>> cmd.iter;
    assign dy_sh  = x_reg >>> cmd.iter;
    assign atan_v = $signed({3'b0, atan_lut(cmd.iter)});
    assign cs     = neg_reg ? -x_reg : x_reg;
    assign sn     = neg_reg ? -y_reg : y_reg;

    always_ff @(posedge aclk) begin
        if (cmd.cordic_init) begin
            x_reg   <= CORDIC_GAIN;
            y_reg   <= '0;
            z_reg   <= $signed({a_fold[15:0], 10'b0});
            neg_reg <= fold_neg;
        end else if (cmd.cordic_step) begin
            if (!z_reg[25]) begin
                x_reg <= x_reg - dx_sh;
                y_reg <= y_reg + dy_sh;
                z_reg <= z_reg - atan_v;
            end else begin
                x_reg <= x_reg + dx_sh;
                y_reg <= y_reg - dy_sh;
                z_reg <= z_reg + atan_v;
            end
        end
    end

    // edge operand selection: walls first, then the edges of each box in turn
    assign edge_off = cmd.edge_idx - EDGE_W'(4);
    assign bsel     = edge_off[BOX_AW+1:2];
    assign bx2      = $signed({bcx_mem[bsel], 1'b0});
    assign by2      = $signed({bcy_mem[bsel], 1'b0});
    assign hw2      = $signed({2'b0, hw_reg, 1'b0});
    assign hh2      = $signed({2'b0, hh_reg, 1'b0});

    always_comb begin
        c_sel = '0;
        if (cmd.edge_idx < EDGE_W'(4)) begin
            unique case (cmd.edge_idx[1:0])
                2'd0:    p_sel = hw2;
                2'd1:    p_sel = -hw2;
                2'd2:    p_sel = hh2;
                default: p_sel = -hh2;
            endcase
            e_sel = cmd.edge_idx[1] ? {hw_reg, 1'b0} : {hh_reg, 1'b0};
        end else begin
            unique case (cmd.edge_idx[1:0])
                2'd0:    p_sel = 18'(bx2) - $signed({2'b0, bw_mem[bsel]});
                2'd1:    p_sel = 18'(bx2) + $signed({2'b0, bw_mem[bsel]});
                2'd2:    p_sel = 18'(by2) + $signed({2'b0, bh_mem[bsel]});
                default: p_sel = 18'(by2) - $signed({2'b0, bh_mem[bsel]});
            endcase
            c_sel = cmd.edge_idx[1] ? bx2 : by2;
            e_sel = cmd.edge_idx[1] ? bw_mem[bsel] : bh_mem[bsel];
        end
        d_sel = cmd.edge_idx[1] ? sn : cs;
        o_sel = cmd.edge_idx[1] ? cs : sn;
    end

    // hit test and division setup
    assign ad     = d_reg[18] ? 18'(-d_reg) : 18'(d_reg);
    assign diff   = 38'(po_reg) - 38'(cd_reg);
    assign adiff  = diff[37] ? 38'(-diff) : 38'(diff);
    assign hit    = pre_ok_reg && (adiff <= {4'b0, ead_reg});
    assign num_hi = {ap_reg[17:0], 15'b0};
    assign sat    = {1'b0, num_hi} >= den_reg;
    assign rem2   = {rem_reg, 1'b0};

    always_ff @(posedge aclk) begin
        if (cmd.edge_sel) begin
            p_reg <= p_sel;
            d_reg <= d_sel;
            o_reg <= o_sel;
            c_reg <= c_sel;
            e_reg <= e_sel;
        end
        if (cmd.edge_mul) begin
            po_reg     <= 37'(p_reg) * 37'(o_reg);
            cd_reg     <= 36'(c_reg) * 36'(d_reg);
            ead_reg    <= 34'(e_reg) * 34'(ad);
            den_reg    <= 34'(ad) * 34'(range_reg);
            ap_reg     <= p_reg[17] ? 18'(-p_reg) : 18'(p_reg);
            pre_ok_reg <= (d_reg != '0) && (p_reg != '0) && (p_reg[17] == d_reg[18]);
        end
        if (cmd.edge_chk) begin
            hit_reg      <= hit;
            need_div_reg <= hit && !sat;
            rem_reg      <= {1'b0, num_hi};
            q_reg        <= sat ? 16'hFFFF : 16'h0000;
        end else if (cmd.div_step) begin
            // one restoring quotient bit per cycle
            if (rem2 >= {1'b0, den_reg}) begin
                rem_reg <= 34'(rem2 - {1'b0, den_reg});
                q_reg   <= {q_reg[14:0], 1'b1};
            end else begin
                rem_reg <= rem2[33:0];
                q_reg   <= {q_reg[14:0], 1'b0};
            end
        end
        if (cmd.cordic_init)
            best_reg <= 16'hFFFF;
        else if (cmd.commit && hit_reg && q_reg < best_reg)
            best_reg <= q_reg;
    end

    assign stat.box_count = cnt_reg;
    assign stat.need_div  = need_div_reg;

    assign res.beam_angle   = ang_reg[14:0];
    assign res.norm_range   = best_reg;
    assign res.budget_spent = idx_next >= budget_reg;

endmodule

@@ rtl/sweeping_ray_box_range_finder.sv @@
// Top level of the sweeping ray/box range finder: stream ports, output register.
// Depends on sray_pkg, sray_ctrl and sray_dp.
//
// A scan item casts one ray at the current beam angle and returns one result item;
// load and restart items return nothing. A scan runs the cordic, then takes each of
// the E = 4 + 4 * (stored boxes) edges through the select, multiply, check and test
// states, with the shared multiplier stage; for each edge the ray hits short of
// saturation the one restoring divider adds a quotient bit per cycle. One item is
// worked at a time; a finished result waits in the output register while the next
// item is taken.
module sweeping_ray_box_range_finder (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [63:0]                 s_tdata,  // box_center_x, box_center_y, box_width, box_height
    input  logic [1:0]                  s_tuser,  // req_type
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [31:0]                 m_tdata,  // beam_angle, norm_range, budget_spent
    input  logic                        cfg_we,
    input  logic [sray_pkg::CFG_AW-1:0] cfg_addr,
    input  logic [sray_pkg::CFG_DW-1:0] cfg_wdata
);
    import sray_pkg::*;

    cmd_t        cmd;
    stat_t       stat;
    res_t        res;
    logic        in_accept;
    logic        out_free;
    logic        m_tvalid_reg, m_tvalid_next;
    logic [31:0] m_tdata_reg, m_tdata_next;

    assign in_accept = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;

    sray_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_accept (in_accept),
        .req_type  (s_tuser),
        .out_free  (out_free),
        .stat      (stat),
        .in_ready  (s_tready),
        .cmd       (cmd)
    );

    sray_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .box_data  (s_tdata),
        .cmd       (cmd),
        .stat      (stat),
        .res       (res)
    );

    // output register
    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        if (cmd.finish) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = res;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn)
            m_tvalid_reg <= 1'b0;
        else
            m_tvalid_reg <= m_tvalid_next;
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule
